// ----- hw/rtl/utf8d_pkg.sv -----
// Shared types and constants for the UTF-8 to code point decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int CpW = 21;
  localparam int StW = 2;

  localparam logic [CpW-1:0] CpMax  = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [StW-1:0] ST_TRUNC    = 2'd2;
  localparam logic [StW-1:0] ST_INVALID  = 2'd3;

  typedef struct packed {
    logic [1:0]     pend;
    logic [CpW-1:0] pv;
    logic           skip;
  } dec_state_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] cp;
    logic [StW-1:0] status;
    logic           fin;
  } dec_res_t;

endpackage

// ----- hw/rtl/utf8_to_codepoint_decoder_top.sv -----
// UTF-8 to code point decoder: top level with input register and decoder state.
// A byte is registered on acceptance and decoded into the output register once that register
// is free, so a result passes the input register and then the output register to out_tvalid.
// Throughput: one byte per cycle while the output register can take a result; else input stalls.
// Bytes that give no result still pass through the input register at the same rate.
// Reset (rst_n low, synchronous) empties both registers and clears the decoder state.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] in_byte
  input  logic                      in_tlast,   // end_of_string
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // [20:0] scalar value, [23:21] zero
  output logic [utf8d_pkg::StW-1:0] out_tuser,  // [1:0] status
  output logic                      out_tlast   // final_result
);
  import utf8d_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       eos_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  dec_res_t   res;
  logic       out_free;
  logic       advance;

  // The held byte moves on whenever the output register can take its result.
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      eos_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  utf8d_step u_step (
    .byte_i (byte_r),
    .eos_i  (eos_r),
    .cur_i  (state_r),
    .nxt_o  (state_nxt),
    .res_o  (res)
  );

  utf8d_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (in_valid_r),
    .res_i      (res),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hw/rtl/utf8d_step.sv -----
// Combinational decode step: one byte against the current decoder state.
`timescale 1ns / 1ps

module utf8d_step (
  input  logic [7:0]           byte_i,
  input  logic                 eos_i,
  input  utf8d_pkg::dec_state_t cur_i,
  output utf8d_pkg::dec_state_t nxt_o,
  output utf8d_pkg::dec_res_t   res_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0] cand;
  logic           do_finish;
  logic           cand_bad;
  logic [1:0]     lead_n;
  logic [CpW-1:0] lead_bits;
  logic           lead_ok;
  logic [1:0]     pend_dec;

  assign pend_dec = cur_i.pend - 2'd1;

  always_comb begin
    lead_ok   = 1'b1;
    lead_n    = 2'd0;
    lead_bits = '0;
    if (byte_i[7:5] == 3'b110) begin
      lead_n    = 2'd1;
      lead_bits = {16'd0, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_n    = 2'd2;
      lead_bits = {17'd0, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_n    = 2'd3;
      lead_bits = {18'd0, byte_i[2:0]};
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    nxt_o      = cur_i;
    res_o      = '0;
    do_finish  = 1'b0;
    cand       = '0;
    cand_bad   = 1'b0;
    if (cur_i.skip) begin
      if (eos_i) begin
        nxt_o = '0;
      end
    end else if (cur_i.pend == 2'd0) begin
      if (!byte_i[7]) begin
        do_finish = 1'b1;
        cand      = {13'd0, byte_i};
      end else if (!lead_ok) begin
        nxt_o      = '0;
        nxt_o.skip = !eos_i;
        res_o      = '{valid: 1'b1, cp: '0, status: ST_BAD_LEAD, fin: 1'b1};
      end else if (eos_i) begin
        nxt_o = '0;
        res_o = '{valid: 1'b1, cp: '0, status: ST_TRUNC, fin: 1'b1};
      end else begin
        nxt_o.pend = lead_n;
        nxt_o.pv   = lead_bits;
      end
    end else begin
      // Marker bits of continuation bytes are not checked.
      cand = {cur_i.pv[CpW-7:0], byte_i[5:0]};
      if (pend_dec == 2'd0) begin
        do_finish = 1'b1;
      end else if (eos_i) begin
        nxt_o = '0;
        res_o = '{valid: 1'b1, cp: '0, status: ST_TRUNC, fin: 1'b1};
      end else begin
        nxt_o.pend = pend_dec;
        nxt_o.pv   = cand;
      end
    end

    cand_bad = (cand > CpMax) || ((cand >= SurrLo) && (cand <= SurrHi));

    if (do_finish) begin
      nxt_o = '0;
      if (cand_bad) begin
        nxt_o.skip = !eos_i;
        res_o      = '{valid: 1'b1, cp: '0, status: ST_INVALID, fin: 1'b1};
      end else begin
        res_o = '{valid: 1'b1, cp: cand, status: ST_OK, fin: eos_i};
      end
    end
  end

endmodule

// ----- hw/rtl/utf8d_out_reg.sv -----
// Output register of the decoder result stream.
`timescale 1ns / 1ps

module utf8d_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_i,
  input  utf8d_pkg::dec_res_t        res_i,
  output logic                       free_o,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,
  output logic [utf8d_pkg::StW-1:0]  out_tuser,
  output logic                       out_tlast
);
  import utf8d_pkg::*;

  logic           valid_r;
  logic [CpW-1:0] cp_r;
  logic [StW-1:0] status_r;
  logic           fin_r;

  assign free_o = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free_o) begin
      valid_r <= load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free_o && load_i && res_i.valid) begin
      cp_r     <= res_i.cp;
      status_r <= res_i.status;
      fin_r    <= res_i.fin;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'd0, cp_r};
  assign out_tuser  = status_r;
  assign out_tlast  = fin_r;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the UTF-8 to code point decoder, random stall on both streams.
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int LongHold  = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } byte_item_t;

  typedef struct {
    logic [CpW-1:0] cp;
    logic [StW-1:0] status;
    logic           last;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [StW-1:0] out_tuser;
  logic out_tlast;

  byte_item_t byte_q[$];
  cp_result_t cp_expect_q[$];
  logic [7:0] str_bytes[$];

  // Decoder state mirrored by the predictor.
  logic [1:0]     pend_bytes = 2'd0;
  logic [CpW-1:0] acc_value = '0;
  logic           dropping = 1'b0;

  int items_in = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit long_hold_done = 0;
  bit got_result;
  cp_result_t next_result;
  cp_result_t seen;
  byte_item_t cur;

  utf8_to_codepoint_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // An error always closes the string; the rest is dropped unless this byte ended it.
  function automatic bit flag_error(input logic [StW-1:0] st, input logic eos,
                                    output cp_result_t res);
    pend_bytes = 2'd0;
    acc_value = '0;
    dropping = !eos;
    res.cp = '0;
    res.status = st;
    res.last = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output cp_result_t res);
    logic [CpW-1:0] val;
    bit done;
    res.cp = '0;
    res.status = ST_OK;
    res.last = 1'b0;
    done = 1'b0;
    val = '0;
    if (dropping) begin
      if (eos) begin
        pend_bytes = 2'd0;
        acc_value = '0;
        dropping = 1'b0;
      end
      return 1'b0;
    end
    if (pend_bytes == 2'd0) begin
      if (!b[7]) begin
        done = 1'b1;
        val = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        pend_bytes = 2'd1;
        acc_value = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        pend_bytes = 2'd2;
        acc_value = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        pend_bytes = 2'd3;
        acc_value = {18'd0, b[2:0]};
      end else begin
        return flag_error(ST_BAD_LEAD, eos, res);
      end
      if (!done && eos) return flag_error(ST_TRUNC, 1'b1, res);
    end else begin
      // Marker bits of continuation bytes are ignored on purpose.
      acc_value = {acc_value[14:0], b[5:0]};
      pend_bytes = pend_bytes - 2'd1;
      if (pend_bytes == 2'd0) begin
        done = 1'b1;
        val = acc_value;
      end else if (eos) begin
        return flag_error(ST_TRUNC, 1'b1, res);
      end
    end
    if (!done) return 1'b0;
    if (val > CpMax || (val >= SurrLo && val <= SurrHi))
      return flag_error(ST_INVALID, eos, res);
    pend_bytes = 2'd0;
    acc_value = '0;
    dropping = 1'b0;
    res.cp = val;
    res.status = ST_OK;
    res.last = eos;
    return 1'b1;
  endfunction

  // Mostly back to back, some short gaps, a few long ones; every fifth stretch runs flat out.
  function automatic int rand_gap();
    int r;
    if ((items_in / 150) % 5 == 4) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eos, input bit drain);
    byte_item_t it;
    it.data = b;
    it.last = eos;
    it.drain = drain;
    byte_q.insert(byte_q.size(), it);
  endtask

  // Encodes cp in n bytes but keeps only the first keep of them.
  task automatic add_char(input logic [CpW-1:0] cp, input int n, input int keep);
    logic [CpW-1:0] sh;
    logic [1:0] mark;
    int k;
    case (n)
      1: str_bytes.insert(str_bytes.size(), {1'b0, cp[6:0]});
      2: str_bytes.insert(str_bytes.size(), {3'b110, cp[10:6]});
      3: str_bytes.insert(str_bytes.size(), {4'b1110, cp[15:12]});
      default: str_bytes.insert(str_bytes.size(), {5'b11110, cp[20:18]});
    endcase
    for (k = 1; k < keep; k++) begin
      sh = cp >> (6 * (n - 1 - k));
      mark = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b10;
      str_bytes.insert(str_bytes.size(), {mark, sh[5:0]});
    end
  endtask

  task automatic add_string(input bit drain);
    int nchar;
    int kind;
    int n;
    int i;
    logic [CpW-1:0] cp;
    str_bytes.delete();
    nchar = $urandom_range(1, 6);
    for (i = 0; i < nchar; i++) begin
      kind = $urandom_range(0, 99);
      n = $urandom_range(1, 4);
      case (n)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range(0, 'h7FF));
        3: cp = 21'($urandom_range(0, 'hFFFF));
        default: cp = ($urandom_range(0, 7) == 0) ? 21'($urandom) :
                                                     21'($urandom_range(0, 'h10FFFF));
      endcase
      if (kind < 65) begin
        add_char(cp, n, n);
      end else if (kind < 73) begin
        add_char(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
      end else if (kind < 82) begin
        str_bytes.insert(str_bytes.size(),
                         $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF)) :
                                                8'($urandom_range('hF8, 'hFF)));
      end else if (kind < 90) begin
        if (n < 2) n = 2;
        add_char(cp, n, $urandom_range(1, n - 1));
      end else begin
        str_bytes.insert(str_bytes.size(), 8'($urandom));
      end
    end
    for (i = 0; i < str_bytes.size(); i++)
      add_byte(str_bytes[i], i == str_bytes.size() - 1, drain && i == 0);
  endtask

  initial begin
    // Plain ASCII at both ends of the range.
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h7F, 1'b1, 1'b0);
    // Overlong encoding of zero passes, then a three-byte character.
    add_byte(8'hC0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);
    add_byte(8'hE2, 1'b0, 1'b0);
    add_byte(8'h82, 1'b0, 1'b0);
    add_byte(8'hAC, 1'b1, 1'b0);
    // Largest legal scalar value.
    add_byte(8'hF4, 1'b0, 1'b0);
    add_byte(8'h8F, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b1, 1'b0);
    // All-ones value, above the legal range, on the final byte.
    add_byte(8'hF7, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b1, 1'b0);
    // Surrogate in mid-string; the remaining bytes are dropped.
    add_byte(8'hED, 1'b0, 1'b0);
    add_byte(8'hA0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h41, 1'b1, 1'b0);
    // Bad lead bytes, as the final byte and in mid-string.
    add_byte(8'h80, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b1);
    add_byte(8'h41, 1'b1, 1'b0);
    // Strings that end inside a sequence, on the lead and on a continuation.
    add_byte(8'hE2, 1'b1, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);
    add_byte(8'h9F, 1'b0, 1'b0);
    add_byte(8'h98, 1'b1, 1'b0);
    // A lead-looking byte is taken as a continuation.
    add_byte(8'hC3, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    while (byte_q.size() < 1530)
      add_string($urandom_range(0, 29) == 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_tvalid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Byte sender; the prediction is made when the transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        got_result = decode_byte(in_tdata, in_tlast, next_result);
        if (got_result) cp_expect_q.insert(cp_expect_q.size(), next_result);
        items_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_q.size() == 0 || (byte_q[0].drain && cp_expect_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          cur = byte_q.pop_front();
          in_tdata <= cur.data;
          in_tlast <= cur.last;
          in_tvalid <= 1'b1;
          send_gap = rand_gap();
        end
      end
    end
  end

  // Result receiver; one long hold-off lets the block back up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (!long_hold_done && items_in >= 600) begin
        long_hold_done = 1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cp_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: data=%h status=%0d last=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        seen = cp_expect_q.pop_front();
        if (out_tdata !== {3'b000, seen.cp} || out_tuser !== seen.status ||
            out_tlast !== seen.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cp=%h status=%0d last=%b, got data=%h status=%0d last=%b",
                     seen.cp, seen.status, seen.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
